[sv/kdec_pkg.sv]
package kdec_pkg;

    // Default depth of the line buffer.
    localparam int KDEC_LINE_DEPTH = 32;

    // Fixed field widths of the request and result.
    localparam int KDEC_IDX_W  = 5;
    localparam int KDEC_LEN_W  = 6;
    localparam int KDEC_CHAR_W = 7;

    // Depth of the result queue in front of the output port.
    localparam int KDEC_FIFO_DEPTH = 3;

    // Request opcodes.
    typedef enum logic [1:0] {
        OP_FEED  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_kdec_op;

    // Result command codes.
    typedef enum logic [3:0] {
        ACT_NONE       = 4'd0,
        ACT_RIGHT      = 4'd1,
        ACT_LEFT       = 4'd2,
        ACT_UP         = 4'd3,
        ACT_DOWN       = 4'd4,
        ACT_MOVE_LEFT  = 4'd5,
        ACT_ENTER      = 4'd6,
        ACT_MOVE_RIGHT = 4'd7,
        ACT_TYPED      = 4'd8,
        ACT_QUIT       = 4'd9
    } t_kdec_cmd;

    // Escape sequence recognizer states.
    typedef enum logic [1:0] {
        SEQ_IDLE    = 2'd0,
        SEQ_ESC     = 2'd1,
        SEQ_BRACKET = 2'd2,
        SEQ_TILDE   = 2'd3
    } t_kdec_seq;

    // Key byte values.
    localparam logic [7:0] KEY_BS        = 8'd8;
    localparam logic [7:0] KEY_LF        = 8'd10;
    localparam logic [7:0] KEY_CR        = 8'd13;
    localparam logic [7:0] KEY_ESC       = 8'd27;
    localparam logic [7:0] KEY_SPACE     = 8'd32;
    localparam logic [7:0] KEY_DIGIT_0   = 8'h30;
    localparam logic [7:0] KEY_DIGIT_1   = 8'h31;
    localparam logic [7:0] KEY_DIGIT_2   = 8'h32;
    localparam logic [7:0] KEY_DIGIT_5   = 8'h35;
    localparam logic [7:0] KEY_DIGIT_9   = 8'h39;
    localparam logic [7:0] KEY_UPPER_A   = 8'h41;
    localparam logic [7:0] KEY_UPPER_B   = 8'h42;
    localparam logic [7:0] KEY_UPPER_C   = 8'h43;
    localparam logic [7:0] KEY_UPPER_D   = 8'h44;
    localparam logic [7:0] KEY_UPPER_Z   = 8'h5A;
    localparam logic [7:0] KEY_LBRACKET  = 8'd91;
    localparam logic [7:0] KEY_BACKQUOTE = 8'd96;
    localparam logic [7:0] KEY_LOWER_A   = 8'h61;
    localparam logic [7:0] KEY_LOWER_Z   = 8'h7A;
    localparam logic [7:0] KEY_TILDE     = 8'd126;
    localparam logic [7:0] KEY_DEL       = 8'd127;

    // Request payload.
    typedef struct packed {
        logic [1:0]            opcode;
        logic [7:0]            in_byte;
        logic [KDEC_IDX_W-1:0] read_index;
    } t_kdec_in;

    // Result payload.
    typedef struct packed {
        logic [3:0]             command;
        logic [KDEC_LEN_W-1:0]  line_length;
        logic [KDEC_CHAR_W-1:0] read_char;
    } t_kdec_out;

    // Result fields registered when a request is accepted, alongside the buffer read.
    typedef struct packed {
        logic [3:0]            command;
        logic [KDEC_LEN_W-1:0] line_length;
        logic                  read_hit;
    } t_kdec_s1;

endpackage

[sv/escape_sequence_key_decoder_core.sv]
// Each accepted request is registered with its buffer read, then queued; o_valid shows a non-empty queue.
// Throughput: one request per cycle while o_ready is high; the line buffer is written or read at most once per cycle.
// Intake stalls when the results queued plus the one in flight reach the queue depth of three.
// Reset (i_rst_n low, synchronous) returns to idle and empties the line and the result queue.
// Buffer contents are not cleared; a read is reported only for positions below the line length.
module escape_sequence_key_decoder_core
    import kdec_pkg::*;
#(
    parameter int LINE_DEPTH = KDEC_LINE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_kdec_in  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_kdec_out o_data
);

    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int NW = $clog2(KDEC_FIFO_DEPTH + 1);
    localparam int QW = NW + 1;

    logic                   w_accept;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [KDEC_CHAR_W-1:0] w_wdata;
    logic                   w_re;
    logic [AW-1:0]          w_raddr;
    logic [KDEC_CHAR_W-1:0] w_rdata;
    logic                   w_s1_valid;
    t_kdec_s1               w_s1;
    t_kdec_out              w_result;
    logic [NW-1:0]          w_fifo_count;
    logic [QW-1:0]          w_in_flight;

    // Accept while the queue has room for every request already in flight.
    assign w_in_flight = QW'(w_fifo_count) + QW'(w_s1_valid);
    assign o_ready     = (w_in_flight < QW'(KDEC_FIFO_DEPTH));
    assign w_accept    = i_valid && o_ready;

    kdec_ctrl #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_req      (i_data),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_re       (w_re),
        .o_raddr    (w_raddr),
        .o_s1_valid (w_s1_valid),
        .o_s1       (w_s1)
    );

    kdec_line_mem #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Merge the buffer read into the result.
    assign w_result.command     = w_s1.command;
    assign w_result.line_length = w_s1.line_length;
    assign w_result.read_char   = w_s1.read_hit ? w_rdata : '0;

    kdec_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_s1_valid),
        .i_push_data (w_result),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .o_count     (w_fifo_count)
    );

endmodule

[sv/kdec_line_mem.sv]
module kdec_line_mem
    import kdec_pkg::*;
#(
    parameter int LINE_DEPTH = KDEC_LINE_DEPTH,
    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  logic [KDEC_CHAR_W-1:0] i_wdata,
    input  logic                   i_re,
    input  logic [AW-1:0]          i_raddr,
    output logic [KDEC_CHAR_W-1:0] o_rdata
);

    logic [KDEC_CHAR_W-1:0] r_mem [LINE_DEPTH];
    logic [KDEC_CHAR_W-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/kdec_ctrl.sv]
module kdec_ctrl
    import kdec_pkg::*;
#(
    parameter int LINE_DEPTH = KDEC_LINE_DEPTH,
    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  t_kdec_in               i_req,
    output logic                   o_we,
    output logic [AW-1:0]          o_waddr,
    output logic [KDEC_CHAR_W-1:0] o_wdata,
    output logic                   o_re,
    output logic [AW-1:0]          o_raddr,
    output logic                   o_s1_valid,
    output t_kdec_s1               o_s1
);

    localparam int CW = $clog2(LINE_DEPTH + 1);
    localparam int XW = (CW > KDEC_IDX_W) ? CW : KDEC_IDX_W;

    t_kdec_seq       r_seq;
    t_kdec_seq       n_seq;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            r_s1_valid;
    t_kdec_s1        r_s1;
    t_kdec_s1        n_s1;

    logic [7:0]      w_byte;
    logic            w_feed;
    logic            w_is_del;
    logic            w_is_typable;
    logic            w_is_newline;
    logic [3:0]      w_seq_cmd;
    logic            w_plain;
    logic            w_full;
    logic [XW-1:0]   w_idx_ext;
    logic [XW-1:0]   w_cnt_ext;

    // Byte classification.
    assign w_byte       = i_req.in_byte;
    assign w_feed       = (i_req.opcode == OP_FEED) && (w_byte != KEY_BACKQUOTE);
    assign w_is_del     = (w_byte == KEY_BS) || (w_byte == KEY_DEL);
    assign w_is_newline = (w_byte == KEY_LF) || (w_byte == KEY_CR);
    assign w_is_typable = ((w_byte >= KEY_UPPER_A) && (w_byte <= KEY_UPPER_Z)) ||
                          ((w_byte >= KEY_LOWER_A) && (w_byte <= KEY_LOWER_Z)) ||
                          ((w_byte >= KEY_DIGIT_0) && (w_byte <= KEY_DIGIT_9)) ||
                          (w_byte == KEY_SPACE) || w_is_del;
    assign w_full       = (r_count == CW'(LINE_DEPTH));

    // Next state of the escape sequence recognizer.
    always_comb begin
        n_seq = r_seq;
        if (i_accept && w_feed) begin
            unique case (r_seq)
                SEQ_IDLE: begin
                    if (w_byte == KEY_ESC) begin
                        n_seq = SEQ_ESC;
                    end
                end
                SEQ_ESC: begin
                    n_seq = (w_byte == KEY_LBRACKET) ? SEQ_BRACKET : SEQ_IDLE;
                end
                SEQ_BRACKET: begin
                    if ((w_byte == KEY_DIGIT_1) || (w_byte == KEY_DIGIT_2) ||
                        (w_byte == KEY_DIGIT_5)) begin
                        n_seq = SEQ_TILDE;
                    end else begin
                        n_seq = SEQ_IDLE;
                    end
                end
                SEQ_TILDE: begin
                    n_seq = SEQ_IDLE;
                end
            endcase
        end
    end

    // Recognizer outputs: the sequence command, or hand the byte to the line editor.
    always_comb begin
        w_seq_cmd = ACT_NONE;
        w_plain   = 1'b0;
        unique case (r_seq)
            SEQ_IDLE: begin
                w_plain = (w_byte != KEY_ESC);
            end
            SEQ_ESC: begin
                w_plain = (w_byte != KEY_LBRACKET);
            end
            SEQ_BRACKET: begin
                unique case (w_byte)
                    KEY_UPPER_A: w_seq_cmd = ACT_UP;
                    KEY_UPPER_B: w_seq_cmd = ACT_DOWN;
                    KEY_UPPER_C: w_seq_cmd = ACT_RIGHT;
                    KEY_UPPER_D: w_seq_cmd = ACT_LEFT;
                    KEY_DIGIT_2: w_seq_cmd = ACT_MOVE_LEFT;
                    KEY_DIGIT_1: w_seq_cmd = ACT_ENTER;
                    KEY_DIGIT_5: w_seq_cmd = ACT_MOVE_RIGHT;
                    default:     w_plain   = 1'b1;
                endcase
            end
            SEQ_TILDE: begin
                w_plain = (w_byte != KEY_TILDE);
            end
        endcase
    end

    // Line editing, buffer access and the command of this request.
    assign w_idx_ext = XW'(i_req.read_index);
    assign w_cnt_ext = XW'(r_count);

    always_comb begin
        n_count          = r_count;
        o_we             = 1'b0;
        o_re             = 1'b0;
        n_s1.command     = ACT_NONE;
        n_s1.read_hit    = 1'b0;
        unique case (t_kdec_op'(i_req.opcode))
            OP_FEED: begin
                if (w_byte == KEY_BACKQUOTE) begin
                    n_s1.command = ACT_QUIT;
                end else if (!w_plain) begin
                    n_s1.command = w_seq_cmd;
                end else if (w_is_typable) begin
                    if (w_is_del) begin
                        if (r_count != '0) begin
                            n_count = r_count - CW'(1);
                        end
                    end else if (!w_full) begin
                        o_we    = i_accept;
                        n_count = r_count + CW'(1);
                    end
                end else if (w_is_newline) begin
                    n_s1.command = ACT_TYPED;
                end
            end
            OP_READ: begin
                o_re          = i_accept;
                n_s1.read_hit = (w_idx_ext < w_cnt_ext);
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        // The reported length is the count after this request, kept to the field width.
        n_s1.line_length = KDEC_LEN_W'(n_count);
    end

    assign o_waddr          = r_count[AW-1:0];
    assign o_wdata          = w_byte[KDEC_CHAR_W-1:0];
    assign o_raddr          = w_idx_ext[AW-1:0];

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= SEQ_IDLE;
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_seq      <= n_seq;
            r_s1_valid <= i_accept;
            if (i_accept) begin
                r_count <= n_count;
            end
        end
    end

    // Result fields waiting for the buffer read.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

[sv/kdec_out_fifo.sv]
module kdec_out_fifo
    import kdec_pkg::*;
#(
    localparam int PW = $clog2(KDEC_FIFO_DEPTH),
    localparam int NW = $clog2(KDEC_FIFO_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_kdec_out     i_push_data,
    input  logic          i_ready,
    output logic          o_valid,
    output t_kdec_out     o_data,
    output logic [NW-1:0] o_count
);

    t_kdec_out      r_mem [KDEC_FIFO_DEPTH];
    logic [PW-1:0]  r_head;
    logic [PW-1:0]  r_tail;
    logic [NW-1:0]  r_count;
    logic [PW-1:0]  n_head;
    logic [PW-1:0]  n_tail;
    logic [NW-1:0]  n_count;
    logic           w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && i_ready;

    // Pointer and fill count update.
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (w_pop) begin
            n_head = (r_head == PW'(KDEC_FIFO_DEPTH - 1)) ? '0 : r_head + PW'(1);
        end
        if (i_push) begin
            n_tail = (r_tail == PW'(KDEC_FIFO_DEPTH - 1)) ? '0 : r_tail + PW'(1);
        end
        if (i_push && !w_pop) begin
            n_count = r_count + NW'(1);
        end else if (!i_push && w_pop) begin
            n_count = r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_push_data;
        end
    end

    assign o_data  = r_mem[r_head];
    assign o_count = r_count;

endmodule

[tb/sv/kdec_key_result_check.sv]
`timescale 1ns / 1ps

module kdec_key_result_check
    import kdec_pkg::*;
#(
    parameter int LINE_DEPTH = KDEC_LINE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    input  logic      i_req_ready,
    input  t_kdec_in  i_req,
    input  logic      i_res_valid,
    input  logic      i_res_ready,
    input  t_kdec_out i_res,
    output int        o_fail_count,
    output int        o_pending_count,
    output int        o_checked_count
);

    // Shadow copy of the decoder state.
    t_kdec_seq              seq_state;
    int                     line_len;
    logic [KDEC_CHAR_W-1:0] line_chars [LINE_DEPTH];

    // Results predicted for accepted requests, oldest first.
    t_kdec_out expected_results[$];

    initial begin
        o_fail_count    = 0;
        o_pending_count = 0;
        o_checked_count = 0;
    end

    // A byte outside any escape sequence: edit the line or report typed.
    function automatic t_kdec_cmd plain_key_command(input logic [7:0] b);
        logic typable;
        typable = (b >= KEY_UPPER_A && b <= KEY_UPPER_Z) ||
                  (b >= KEY_LOWER_A && b <= KEY_LOWER_Z) ||
                  (b >= KEY_DIGIT_0 && b <= KEY_DIGIT_9) ||
                  b == KEY_SPACE || b == KEY_BS || b == KEY_DEL;
        if (typable) begin
            if (b == KEY_BS || b == KEY_DEL) begin
                if (line_len > 0)
                    line_len--;
            end else if (line_len < LINE_DEPTH) begin
                line_chars[line_len] = b[KDEC_CHAR_W-1:0];
                line_len++;
            end
        end else if (b == KEY_LF || b == KEY_CR) begin
            return ACT_TYPED;
        end
        return ACT_NONE;
    endfunction

    // Advance the shadow state by one request and return its result.
    function automatic t_kdec_out predict_key_result(input t_kdec_in req);
        t_kdec_out res;
        t_kdec_cmd cmd;
        logic [7:0] b;
        res = '0;
        cmd = ACT_NONE;
        b   = req.in_byte;
        case (t_kdec_op'(req.opcode))
            OP_FEED: begin
                // A backquote quits from any state and changes nothing else.
                if (b == KEY_BACKQUOTE) begin
                    cmd = ACT_QUIT;
                end else begin
                    case (seq_state)
                        SEQ_IDLE: begin
                            if (b == KEY_ESC)
                                seq_state = SEQ_ESC;
                            else
                                cmd = plain_key_command(b);
                        end
                        SEQ_ESC: begin
                            // A second ESC falls through to plain handling and is dropped.
                            if (b == KEY_LBRACKET) begin
                                seq_state = SEQ_BRACKET;
                            end else begin
                                seq_state = SEQ_IDLE;
                                cmd = plain_key_command(b);
                            end
                        end
                        SEQ_BRACKET: begin
                            seq_state = SEQ_IDLE;
                            case (b)
                                KEY_UPPER_A: cmd = ACT_UP;
                                KEY_UPPER_B: cmd = ACT_DOWN;
                                KEY_UPPER_C: cmd = ACT_RIGHT;
                                KEY_UPPER_D: cmd = ACT_LEFT;
                                KEY_DIGIT_2: begin
                                    cmd = ACT_MOVE_LEFT;
                                    seq_state = SEQ_TILDE;
                                end
                                KEY_DIGIT_1: begin
                                    cmd = ACT_ENTER;
                                    seq_state = SEQ_TILDE;
                                end
                                KEY_DIGIT_5: begin
                                    cmd = ACT_MOVE_RIGHT;
                                    seq_state = SEQ_TILDE;
                                end
                                default: cmd = plain_key_command(b);
                            endcase
                        end
                        default: begin
                            // The trailing tilde is swallowed; anything else is a plain byte.
                            seq_state = SEQ_IDLE;
                            if (b != KEY_TILDE)
                                cmd = plain_key_command(b);
                        end
                    endcase
                end
            end
            OP_READ: begin
                if (req.read_index < line_len)
                    res.read_char = line_chars[req.read_index];
            end
            OP_CLEAR: line_len = 0;
            default: ;
        endcase
        res.command     = cmd;
        res.line_length = line_len[KDEC_LEN_W-1:0];
        return res;
    endfunction

    // Compare results first, then predict the request taken at the same edge.
    always @(posedge i_clk) begin
        t_kdec_out want;
        if (!i_rst_n) begin
            seq_state = SEQ_IDLE;
            line_len  = 0;
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request pending: command %0d, length %0d, char %0d",
                           i_res.command, i_res.line_length, i_res.read_char);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    o_checked_count++;
                    if (i_res.command !== want.command) begin
                        $error("command: expected %0d, got %0d", want.command, i_res.command);
                        o_fail_count++;
                    end
                    if (i_res.line_length !== want.line_length) begin
                        $error("line_length: expected %0d, got %0d",
                               want.line_length, i_res.line_length);
                        o_fail_count++;
                    end
                    if (i_res.read_char !== want.read_char) begin
                        $error("read_char: expected %0d, got %0d",
                               want.read_char, i_res.read_char);
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                expected_results.push_back(predict_key_result(i_req));
        end
        o_pending_count <= expected_results.size();
    end

endmodule

[tb/sv/escape_sequence_key_decoder_core_tb.sv]
`timescale 1ns / 1ps

module escape_sequence_key_decoder_core_tb;
    import kdec_pkg::*;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    t_kdec_in  req       = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    t_kdec_out res;

    int fail_count;
    int pending_count;
    int checked_count;

    // Requests accepted, total and per opcode.
    int sent;
    int op_seen [4];

    // While set, neither side idles.
    bit free_run;
    int stall_left;

    escape_sequence_key_decoder_core DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (req_valid),
        .o_ready (req_ready),
        .i_data  (req),
        .o_valid (res_valid),
        .i_ready (res_ready),
        .o_data  (res)
    );

    kdec_key_result_check u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (req_valid),
        .i_req_ready     (req_ready),
        .i_req           (req),
        .i_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .i_res           (res),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count),
        .o_checked_count (checked_count)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_kdec_in mk_request(input t_kdec_op op, input logic [7:0] b,
                                            input logic [KDEC_IDX_W-1:0] idx);
        t_kdec_in r;
        r.opcode     = op;
        r.in_byte    = b;
        r.read_index = idx;
        return r;
    endfunction

    // Feed request with a random, unused read index.
    function automatic t_kdec_in key_request(input logic [7:0] b);
        return mk_request(OP_FEED, b, KDEC_IDX_W'($urandom_range(0, 31)));
    endfunction

    // Random letter, digit or space.
    function automatic logic [7:0] key_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26)
            return KEY_UPPER_A + 8'(r);
        else if (r < 52)
            return KEY_LOWER_A + 8'(r - 26);
        else if (r < 62)
            return KEY_DIGIT_0 + 8'(r - 52);
        return KEY_SPACE;
    endfunction

    // Result side: random stalls unless in a free-running stretch.
    always @(posedge clk) begin
        if (free_run) begin
            res_ready <= 1'b1;
        end else if (stall_left != 0) begin
            res_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < 25) begin
            stall_left = idle_len();
            res_ready <= 1'b0;
        end else begin
            res_ready <= 1'b1;
        end
    end

    // Present one request after an optional gap and hold it until accepted.
    task automatic send_request(input t_kdec_in item);
        int gap;
        gap = free_run ? 0 : idle_len();
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (!req_ready);
        sent++;
        op_seen[item.opcode]++;
    endtask

    // Stop sending until every predicted result has been returned.
    task automatic wait_for_results();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    // Well-formed escape sequence, occasionally with a quit inside it.
    task automatic send_escape_sequence();
        logic [7:0] finals [7];
        logic [7:0] last;
        finals = '{KEY_UPPER_A, KEY_UPPER_B, KEY_UPPER_C, KEY_UPPER_D,
                   KEY_DIGIT_1, KEY_DIGIT_2, KEY_DIGIT_5};
        last = finals[$urandom_range(0, 6)];
        send_request(key_request(KEY_ESC));
        if ($urandom_range(0, 19) == 0)
            send_request(key_request(KEY_BACKQUOTE));
        send_request(key_request(KEY_LBRACKET));
        send_request(key_request(last));
        if ((last == KEY_DIGIT_1 || last == KEY_DIGIT_2 || last == KEY_DIGIT_5) &&
            $urandom_range(0, 9) < 7)
            send_request(key_request(KEY_TILDE));
    endtask

    initial begin
        t_kdec_in directed [$];
        int kind;
        int next_switch;
        bit drained_mid;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: empty-buffer edits, reads past the end, several escape forms.
        directed = '{
            key_request(KEY_BS), key_request(KEY_DEL),
            mk_request(OP_READ, 8'hFF, 5'd0),
            key_request(KEY_UPPER_A), key_request(KEY_LOWER_Z),
            key_request(KEY_DIGIT_0), key_request(KEY_SPACE),
            mk_request(OP_READ, 8'h00, 5'd0), mk_request(OP_READ, 8'h00, 5'd31),
            key_request(KEY_ESC), key_request(KEY_BACKQUOTE),
            key_request(KEY_LBRACKET), key_request(KEY_UPPER_D),
            key_request(KEY_ESC), key_request(KEY_LBRACKET), key_request(KEY_DIGIT_5),
            key_request(KEY_TILDE),
            key_request(KEY_ESC), key_request(KEY_LBRACKET), key_request(KEY_DIGIT_1),
            key_request(KEY_LOWER_A + 8'd23), key_request(8'hFF), key_request(8'h00),
            key_request(KEY_CR),
            mk_request(OP_NOP, 8'hFF, 5'd31), mk_request(OP_CLEAR, 8'h00, 5'd0)
        };
        foreach (directed[i])
            send_request(directed[i]);
        wait_for_results();

        // Random part: mostly well-formed traffic, some noise and broken sequences.
        next_switch = sent + $urandom_range(60, 120);
        drained_mid = 1'b0;
        while (sent < 525) begin
            if (sent >= next_switch) begin
                free_run    = !free_run;
                next_switch = sent + (free_run ? 30 : $urandom_range(60, 120));
            end
            if (!drained_mid && sent >= 300) begin
                wait_for_results();
                drained_mid = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 28) begin
                send_request(key_request(key_char()));
            end else if (kind < 42) begin
                send_escape_sequence();
            end else if (kind < 50) begin
                send_request(key_request($urandom_range(0, 1) ? KEY_BS : KEY_DEL));
            end else if (kind < 54) begin
                send_request(key_request($urandom_range(0, 1) ? KEY_CR : KEY_LF));
            end else if (kind < 64) begin
                send_request(mk_request(OP_READ, 8'($urandom_range(0, 255)),
                                        KDEC_IDX_W'($urandom_range(0, 31))));
            end else if (kind < 67) begin
                send_request(mk_request(OP_CLEAR, 8'($urandom_range(0, 255)),
                                        KDEC_IDX_W'($urandom_range(0, 31))));
            end else if (kind < 70) begin
                send_request(mk_request(OP_NOP, 8'($urandom_range(0, 255)),
                                        KDEC_IDX_W'($urandom_range(0, 31))));
            end else if (kind < 73) begin
                send_request(key_request(KEY_BACKQUOTE));
            end else if (kind < 86) begin
                send_request(key_request(8'($urandom_range(0, 255))));
            end else if (kind < 97) begin
                // Broken sequence: ESC, maybe a bracket, then any byte.
                send_request(key_request(KEY_ESC));
                if ($urandom_range(0, 1))
                    send_request(key_request(KEY_LBRACKET));
                send_request(key_request(8'($urandom_range(0, 255))));
            end else begin
                // Overfill the line, then read its last position and a random one.
                send_request(mk_request(OP_CLEAR, 8'h00, 5'd0));
                repeat (KDEC_LINE_DEPTH + 2)
                    send_request(key_request(key_char()));
                send_request(mk_request(OP_READ, 8'h00, 5'd31));
                send_request(mk_request(OP_READ, 8'h00, KDEC_IDX_W'($urandom_range(0, 31))));
                send_request(key_request(KEY_DEL));
            end
        end

        wait_for_results();
        repeat (4) @(posedge clk);
        $display("Covered %0d requests: %0d key bytes, %0d reads, %0d clears, %0d no-ops.",
                 sent, op_seen[OP_FEED], op_seen[OP_READ], op_seen[OP_CLEAR], op_seen[OP_NOP]);
        $display("Compared %0d results field by field.", checked_count);
        if (fail_count == 0 && pending_count == 0)
            $display("PASS escape_sequence_key_decoder_core");
        else
            $display("FAIL escape_sequence_key_decoder_core");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #1_000_000;
        $display("FAIL escape_sequence_key_decoder_core");
        $finish;
    end

endmodule
